FILE: design/pbu_pkg.sv
package pbu_pkg;

  localparam int NUM_DIMS   = 7;
  localparam int LEN_BITS   = 10;
  localparam int MAX_VARS   = 8;
  localparam int VAR_DIM    = NUM_DIMS - 1;
  localparam int OFF_W      = 60;
  localparam int VAR_W      = 3;
  localparam int CFG_W      = 60;
  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  // element type codes
  localparam logic [2:0] TYP_I8  = 3'd0;
  localparam logic [2:0] TYP_I16 = 3'd1;
  localparam logic [2:0] TYP_I32 = 3'd2;
  localparam logic [2:0] TYP_F32 = 3'd3;
  localparam logic [2:0] TYP_F64 = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_LENGTHS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_ORDER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_TYPES     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_READ_MASK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BYTES    = 3'd6;

  // one assembled element, handed from front to back
  typedef struct packed {
    logic                                written;
    logic [VAR_W-1:0]                    var_index;
    logic [2:0]                          code;
    logic [63:0]                         raw;
    logic [NUM_DIMS-1:0][LEN_BITS-1:0]   cnt;
    logic [NUM_DIMS-1:0][OFF_W-1:0]      lstr;
    logic                                last;
  } elem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  typedef struct packed {
    logic busy;
    logic push;
  } front_st_t;

endpackage

FILE: design/permuted_binary_unpacker_top.sv
// Permuted binary unpacker.
// Input channel: one raw file byte per word (in_mode = 0), or a restart
// word (in_mode = 1) that clears the walk, reloads the skip count and
// rebuilds the stride table from dim_lengths.
// Output channel: one word per finished element: variable, permuted
// offset, IEEE double bits, stored flag and end-of-walk flag.
// Throughput: one input word per cycle while in_stall is low. After reset
// and after each restart in_stall stays high while the stride builder
// forms one running product of the dimension lengths per cycle.
// A byte that completes an element is written into the queue at the
// accepting edge, then passes the three conversion/offset stages s1 to s3
// and then the out reg before it shows on the output.
// A 4-entry queue sits between the byte front end and the conversion back
// end; when the receiver stalls, the back end holds its stages and the
// queue fills, then in_stall rises. Nothing is dropped.
// Config writes (cfg_we) take effect at the next edge; write only while
// no results are pending.
module permuted_binary_unpacker_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_written,
  output logic [2:0]                     out_var_index,
  output logic [59:0]                    out_element_offset,
  output logic [63:0]                    out_value_bits,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [pbu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbu_pkg::CFG_W-1:0]      cfg_wdata
);

  pbu_pkg::elem_t     push_elem, head;
  pbu_pkg::fifo_st_t  fifo_st;
  pbu_pkg::front_st_t front_st;
  logic               pop;

  // front end: skip, byte gathering, loop counters
  pbu_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_data_byte(in_data_byte),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fifo_st(fifo_st), .push_elem(push_elem), .front_st(front_st)
  );

  pbu_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(front_st.push), .push_elem(push_elem),
    .pop(pop), .head(head), .st(fifo_st)
  );

  // back end: offset products and double conversion
  pbu_back u_back (
    .clk(clk), .rst_n(rst_n),
    .head(head), .fifo_st(fifo_st), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_written(out_written), .out_var_index(out_var_index),
    .out_element_offset(out_element_offset), .out_value_bits(out_value_bits),
    .out_last(out_last)
  );

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    front_st.busy |-> in_stall)
    else $error("input taken while strides are built");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    front_st.push |-> !fifo_st.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_st.empty)
    else $error("pop from empty queue");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

endmodule

FILE: design/pbu_front.sv
module pbu_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [7:0]                      in_data_byte,
  input  logic                            cfg_we,
  input  logic [pbu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbu_pkg::CFG_W-1:0]       cfg_wdata,
  input  pbu_pkg::fifo_st_t               fifo_st,
  output pbu_pkg::elem_t                  push_elem,
  output pbu_pkg::front_st_t              front_st
);

  localparam int NSP = pbu_pkg::VAR_DIM;

  logic [59:0] dim_lengths_r;
  logic [20:0] dim_order_r;
  logic        swap_r;
  logic [3:0]  var_count_r;
  logic [23:0] var_types_r;
  logic [7:0]  read_mask_r;
  logic [15:0] skip_bytes_r;

  logic [pbu_pkg::NUM_DIMS-1:0][pbu_pkg::LEN_BITS-1:0] cnt_r, cnt_nxt;
  logic [NSP-1:0][pbu_pkg::OFF_W-1:0]                  stride_r;
  logic [59:0] snap_r;
  logic [2:0]  step_r;
  logic        busy_r;
  logic [63:0] asm_r, asm_nxt;
  logic [3:0]  held_r, held_nxt;
  logic [15:0] skip_r;
  logic        done_r;

  logic        accept, restart, data_go;
  logic [pbu_pkg::NUM_DIMS-1:0][2:0]                   ldim;
  logic [pbu_pkg::NUM_DIMS-1:0][pbu_pkg::LEN_BITS-1:0] llen;
  logic [pbu_pkg::NUM_DIMS-1:0][pbu_pkg::OFF_W-1:0]    lstr;
  logic        any_zero;
  logic [2:0]  vlvl;
  logic [2:0]  var_sel;
  logic [2:0]  code;
  logic [3:0]  size;
  logic        complete;
  logic [63:0] raw;
  logic        carry;
  logic [3:0]  vc_eff;
  logic [pbu_pkg::OFF_W-1:0] prev_stride;
  logic [pbu_pkg::LEN_BITS-1:0] prev_len;
  logic [69:0] prod;

  assign in_stall = busy_r | fifo_st.full;
  assign accept   = in_valid & ~in_stall;
  assign restart  = accept & in_mode;
  assign data_go  = accept & ~in_mode & (skip_r == 16'd0) & ~done_r & ~any_zero;

  assign vc_eff = (var_count_r > 4'(pbu_pkg::MAX_VARS)) ? 4'(pbu_pkg::MAX_VARS) : var_count_r;

  always_comb begin
    any_zero = 1'b0;
    vlvl     = 3'(pbu_pkg::VAR_DIM);
    for (int l = 0; l < pbu_pkg::NUM_DIMS; l++) begin
      ldim[l] = dim_order_r[3*l +: 3];
      llen[l] = pbu_pkg::LEN_BITS'(1);
      lstr[l] = '0;
      for (int d = 0; d < NSP; d++) begin
        if (ldim[l] == 3'(d)) begin
          llen[l] = dim_lengths_r[d*pbu_pkg::LEN_BITS +: pbu_pkg::LEN_BITS];
          lstr[l] = stride_r[d];
        end
      end
      if (ldim[l] == 3'(pbu_pkg::VAR_DIM)) begin
        llen[l] = pbu_pkg::LEN_BITS'(vc_eff);
        vlvl    = 3'(l);
      end
      if (llen[l] == '0) any_zero = 1'b1;
    end
  end

  always_comb begin
    var_sel = '0;
    for (int l = 0; l < pbu_pkg::NUM_DIMS; l++) begin
      if (vlvl == 3'(l)) var_sel = cnt_r[l][2:0];
    end
    code = var_types_r[3*var_sel +: 3];
    case (code)
      pbu_pkg::TYP_I16: size = 4'd2;
      pbu_pkg::TYP_I32: size = 4'd4;
      pbu_pkg::TYP_F32: size = 4'd4;
      pbu_pkg::TYP_F64: size = 4'd8;
      default:          size = 4'd1;
    endcase
  end

  // byte gathering
  always_comb begin
    asm_nxt  = asm_r;
    held_nxt = held_r;
    if (held_r < 4'd8) begin
      asm_nxt  = asm_r | (64'(in_data_byte) << (8 * held_r[2:0]));
      held_nxt = held_r + 4'd1;
    end
    complete = held_nxt >= size;
    raw = '0;
    case (size)
      4'd2: raw = swap_r ? {48'd0, asm_nxt[7:0], asm_nxt[15:8]} : {48'd0, asm_nxt[15:0]};
      4'd4: raw = swap_r ? {32'd0, asm_nxt[7:0], asm_nxt[15:8], asm_nxt[23:16], asm_nxt[31:24]}
                         : {32'd0, asm_nxt[31:0]};
      4'd8: raw = swap_r ? {asm_nxt[7:0], asm_nxt[15:8], asm_nxt[23:16], asm_nxt[31:24],
                            asm_nxt[39:32], asm_nxt[47:40], asm_nxt[55:48], asm_nxt[63:56]}
                         : asm_nxt;
      default: raw = {56'd0, asm_nxt[7:0]};
    endcase
  end

  // odometer step, innermost level first
  always_comb begin
    carry = 1'b1;
    for (int l = 0; l < pbu_pkg::NUM_DIMS; l++) begin
      cnt_nxt[l] = cnt_r[l];
      if (carry) begin
        if (11'(cnt_r[l]) + 11'd1 < 11'(llen[l])) begin
          cnt_nxt[l] = cnt_r[l] + pbu_pkg::LEN_BITS'(1);
          carry      = 1'b0;
        end else begin
          cnt_nxt[l] = '0;
        end
      end
    end
  end

  assign front_st.busy = busy_r;
  assign front_st.push = data_go & complete;

  always_comb begin
    push_elem.written   = read_mask_r[var_sel];
    push_elem.var_index = var_sel;
    push_elem.code      = code;
    push_elem.raw       = raw;
    push_elem.cnt       = cnt_r;
    push_elem.lstr      = lstr;
    push_elem.last      = carry;
  end

  // stride builder: one running product per cycle
  always_comb begin
    prev_stride = '0;
    prev_len    = '0;
    for (int k = 1; k < NSP; k++) begin
      if (step_r == 3'(k)) begin
        prev_stride = stride_r[k-1];
        prev_len    = snap_r[(k-1)*pbu_pkg::LEN_BITS +: pbu_pkg::LEN_BITS];
      end
    end
    prod = prev_stride * prev_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_lengths_r <= '0;
      dim_order_r   <= 21'd1754760;
      swap_r        <= 1'b0;
      var_count_r   <= 4'd1;
      var_types_r   <= '0;
      read_mask_r   <= 8'hFF;
      skip_bytes_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pbu_pkg::CFG_DIM_LENGTHS:   dim_lengths_r <= cfg_wdata[59:0];
        pbu_pkg::CFG_DIM_ORDER:     dim_order_r   <= cfg_wdata[20:0];
        pbu_pkg::CFG_SWAP_BYTES:    swap_r        <= cfg_wdata[0];
        pbu_pkg::CFG_VAR_COUNT:     var_count_r   <= cfg_wdata[3:0];
        pbu_pkg::CFG_VAR_TYPES:     var_types_r   <= cfg_wdata[23:0];
        pbu_pkg::CFG_VAR_READ_MASK: read_mask_r   <= cfg_wdata[7:0];
        pbu_pkg::CFG_SKIP_BYTES:    skip_bytes_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      asm_r       <= '0;
      held_r      <= '0;
      skip_r      <= '0;
      done_r      <= 1'b0;
      snap_r      <= '0;
      stride_r[0] <= pbu_pkg::OFF_W'(1);
      busy_r      <= 1'b1;
      step_r      <= 3'd1;
    end else if (restart) begin
      cnt_r       <= '0;
      asm_r       <= '0;
      held_r      <= '0;
      skip_r      <= skip_bytes_r;
      done_r      <= 1'b0;
      snap_r      <= dim_lengths_r;
      stride_r[0] <= pbu_pkg::OFF_W'(1);
      busy_r      <= 1'b1;
      step_r      <= 3'd1;
    end else begin
      if (busy_r) begin
        for (int k = 1; k < NSP; k++) begin
          if (step_r == 3'(k)) stride_r[k] <= prod[pbu_pkg::OFF_W-1:0];
        end
        step_r <= step_r + 3'd1;
        if (step_r == 3'(NSP - 1)) busy_r <= 1'b0;
      end
      if (accept && skip_r != 16'd0) skip_r <= skip_r - 16'd1;
      if (data_go) begin
        if (complete) begin
          asm_r  <= '0;
          held_r <= '0;
          cnt_r  <= cnt_nxt;
          if (carry) done_r <= 1'b1;
        end else begin
          asm_r  <= asm_nxt;
          held_r <= held_nxt;
        end
      end
    end
  end

endmodule

FILE: design/pbu_fifo.sv
module pbu_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pbu_pkg::elem_t     push_elem,
  input  logic               pop,
  output pbu_pkg::elem_t     head,
  output pbu_pkg::fifo_st_t  st
);

  pbu_pkg::elem_t                 mem_r [pbu_pkg::FIFO_DEPTH];
  logic [pbu_pkg::FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [pbu_pkg::FIFO_PTR_W:0]   cnt_r;

  assign head     = mem_r[rp_r];
  assign st.full  = cnt_r == (pbu_pkg::FIFO_PTR_W+1)'(pbu_pkg::FIFO_DEPTH);
  assign st.empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_elem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + pbu_pkg::FIFO_PTR_W'(1);
      if (pop)  rp_r <= rp_r + pbu_pkg::FIFO_PTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (pbu_pkg::FIFO_PTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (pbu_pkg::FIFO_PTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: design/pbu_back.sv
module pbu_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pbu_pkg::elem_t                head,
  input  pbu_pkg::fifo_st_t             fifo_st,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_written,
  output logic [2:0]                    out_var_index,
  output logic [59:0]                   out_element_offset,
  output logic [63:0]                   out_value_bits,
  output logic                          out_last
);

  localparam int N  = pbu_pkg::NUM_DIMS;
  localparam int OW = pbu_pkg::OFF_W;

  logic adv;

  // stage 1: products, magnitude
  logic              s1_v_r;
  logic [N-1:0][OW-1:0] s1_p_r;
  logic [31:0]       s1_mag_r;
  logic              s1_neg_r;
  logic [2:0]        s1_code_r;
  logic [63:0]       s1_raw_r;
  logic              s1_wr_r, s1_last_r;
  logic [2:0]        s1_var_r;
  // stage 2: pair sums, leading one position
  logic              s2_v_r;
  logic [3:0][OW-1:0] s2_s_r;
  logic [31:0]       s2_mag_r;
  logic [4:0]        s2_pos_r;
  logic              s2_neg_r;
  logic [2:0]        s2_code_r;
  logic [63:0]       s2_raw_r;
  logic              s2_wr_r, s2_last_r;
  logic [2:0]        s2_var_r;
  // stage 3: quad sums, normalized mantissa
  logic              s3_v_r;
  logic [1:0][OW-1:0] s3_s_r;
  logic [31:0]       s3_norm_r;
  logic              s3_zero_r;
  logic [4:0]        s3_pos_r;
  logic              s3_neg_r;
  logic [2:0]        s3_code_r;
  logic [63:0]       s3_raw_r;
  logic              s3_wr_r, s3_last_r;
  logic [2:0]        s3_var_r;

  logic [31:0] sv;
  logic        neg;
  logic [31:0] mag;
  logic [4:0]  pos;
  logic [63:0] dbl;
  logic [10:0] iexp;

  assign adv = ~out_valid | ~out_stall;
  assign pop = adv & ~fifo_st.empty;

  always_comb begin
    case (head.code)
      pbu_pkg::TYP_I16: sv = {{16{head.raw[15]}}, head.raw[15:0]};
      pbu_pkg::TYP_I32: sv = head.raw[31:0];
      pbu_pkg::TYP_F32: sv = {9'd0, head.raw[22:0]};
      pbu_pkg::TYP_F64: sv = '0;
      default:          sv = {{24{head.raw[7]}}, head.raw[7:0]};
    endcase
    neg = (head.code == pbu_pkg::TYP_F32) ? 1'b0 : sv[31];
    mag = neg ? (32'd0 - sv) : sv;
  end

  always_comb begin
    pos = '0;
    for (int b = 0; b < 32; b++) begin
      if (s1_mag_r[b]) pos = 5'(b);
    end
  end

  always_comb begin
    iexp = 11'd1023 + 11'(s3_pos_r);
    case (s3_code_r)
      pbu_pkg::TYP_F64: dbl = s3_raw_r;
      pbu_pkg::TYP_F32: begin
        if (s3_raw_r[30:23] == 8'hFF) begin
          if (s3_raw_r[22:0] == '0) dbl = {s3_raw_r[31], 11'h7FF, 52'd0};
          else dbl = {s3_raw_r[31], 11'h7FF, 1'b1, s3_raw_r[21:0], 29'd0};
        end else if (s3_raw_r[30:23] == 8'h00) begin
          if (s3_zero_r) dbl = {s3_raw_r[31], 63'd0};
          else dbl = {s3_raw_r[31], 11'd874 + 11'(s3_pos_r), s3_norm_r[30:0], 21'd0};
        end else begin
          dbl = {s3_raw_r[31], 11'(s3_raw_r[30:23]) + 11'd896, s3_raw_r[22:0], 29'd0};
        end
      end
      default: begin
        if (s3_zero_r) dbl = '0;
        else dbl = {s3_neg_r, iexp, s3_norm_r[30:0], 21'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v_r    <= pop;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      out_valid <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < N; l++) begin
        s1_p_r[l] <= OW'(head.lstr[l] * head.cnt[l]);
      end
      s1_mag_r  <= mag;
      s1_neg_r  <= neg;
      s1_code_r <= head.code;
      s1_raw_r  <= head.raw;
      s1_wr_r   <= head.written;
      s1_last_r <= head.last;
      s1_var_r  <= head.var_index;

      s2_s_r[0] <= s1_p_r[0] + s1_p_r[1];
      s2_s_r[1] <= s1_p_r[2] + s1_p_r[3];
      s2_s_r[2] <= s1_p_r[4] + s1_p_r[5];
      s2_s_r[3] <= s1_p_r[6];
      s2_mag_r  <= s1_mag_r;
      s2_pos_r  <= pos;
      s2_neg_r  <= s1_neg_r;
      s2_code_r <= s1_code_r;
      s2_raw_r  <= s1_raw_r;
      s2_wr_r   <= s1_wr_r;
      s2_last_r <= s1_last_r;
      s2_var_r  <= s1_var_r;

      s3_s_r[0] <= s2_s_r[0] + s2_s_r[1];
      s3_s_r[1] <= s2_s_r[2] + s2_s_r[3];
      s3_norm_r <= s2_mag_r << (5'd31 - s2_pos_r);
      s3_zero_r <= s2_mag_r == '0;
      s3_pos_r  <= s2_pos_r;
      s3_neg_r  <= s2_neg_r;
      s3_code_r <= s2_code_r;
      s3_raw_r  <= s2_raw_r;
      s3_wr_r   <= s2_wr_r;
      s3_last_r <= s2_last_r;
      s3_var_r  <= s2_var_r;

      out_element_offset <= s3_s_r[0] + s3_s_r[1];
      out_value_bits     <= dbl;
      out_written        <= s3_wr_r;
      out_var_index      <= s3_var_r;
      out_last           <= s3_last_r;
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;

  localparam logic [59:0] M60 = 60'hFFF_FFFF_FFFF_FFFF;

  // one finished element as seen on the output channel
  typedef struct {
    logic        written;
    logic [2:0]  vidx;
    logic [59:0] offset;
    logic [63:0] value;
    logic        last;
  } elem_word_t;

  // directed stimulus row; when typed is set the value is taken from the row
  typedef struct {
    logic        mode;
    logic [7:0]  data;
    logic        typed;
    logic [63:0] value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_written;
  logic [2:0] out_var_index;
  logic [59:0] out_element_offset;
  logic [63:0] out_value_bits;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [pbu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pbu_pkg::CFG_W-1:0] cfg_wdata = '0;

  permuted_binary_unpacker_top dut (.*);

  always #5 clk = ~clk;

  // shadow copy of the configuration registers
  logic [59:0] sh_lengths;
  logic [20:0] sh_order;
  logic        sh_swap;
  logic [3:0]  sh_nvars;
  logic [23:0] sh_types;
  logic [7:0]  sh_mask;
  logic [15:0] sh_skip;

  // shadow of the walk state
  int unsigned walk_cnt [pbu_pkg::NUM_DIMS];
  logic [59:0] walk_stride [pbu_pkg::NUM_DIMS];
  logic [63:0] gather;
  int unsigned gathered;
  int unsigned skip_left;
  bit          walk_over;

  elem_word_t pending_elems [$];
  int unsigned mismatches = 0;
  bit quiet = 1'b0;

  function automatic int unsigned dim_size(int unsigned d);
    if (d < pbu_pkg::VAR_DIM) return sh_lengths[d*pbu_pkg::LEN_BITS +: pbu_pkg::LEN_BITS];
    if (d == pbu_pkg::VAR_DIM)
      return (sh_nvars > pbu_pkg::MAX_VARS) ? pbu_pkg::MAX_VARS : sh_nvars;
    return 1;
  endfunction

  function automatic int unsigned lvl_dim(int unsigned l);
    return sh_order[3*l +: 3];
  endfunction

  function automatic void walk_restart();
    for (int i = 0; i < pbu_pkg::NUM_DIMS; i++) walk_cnt[i] = 0;
    walk_stride[0] = 60'd1;
    for (int i = 1; i < pbu_pkg::VAR_DIM; i++)
      walk_stride[i] = 60'(64'(walk_stride[i-1]) * dim_size(i - 1));
    walk_stride[pbu_pkg::VAR_DIM] = '0;
    gather = '0;
    gathered = 0;
    skip_left = sh_skip;
    walk_over = 1'b0;
  endfunction

  function automatic logic [63:0] int_to_double(longint v);
    return $realtobits(real'(v));
  endfunction

  // widening float conversion; NaNs come out quiet with the payload kept
  function automatic logic [63:0] single_to_double(logic [31:0] b);
    logic [63:0] s;
    logic [7:0]  e;
    logic [63:0] m;
    int          ex;
    s = 64'(b[31]) << 63;
    e = b[30:23];
    m = 64'(b[22:0]);
    if (e == 8'hFF) begin
      if (m == 0) return s | (64'h7FF << 52);
      return s | (64'h7FF << 52) | (64'd1 << 51) | (m << 29);
    end
    if (e == 0) begin
      if (m == 0) return s;
      ex = 1;
      while (m[23] == 1'b0) begin
        m = m << 1;
        ex--;
      end
      m[23] = 1'b0;
    end else begin
      ex = e;
    end
    return s | (64'(ex + 896) << 52) | (m << 29);
  endfunction

  // advance the walk by one accepted input word; returns 1 if an element finishes
  function automatic bit unpack_step(logic mode, logic [7:0] data, output elem_word_t w);
    int unsigned vlvl, vsel, size;
    logic [2:0]  code;
    logic [63:0] raw, off;
    bit          fin;
    if (mode) begin
      walk_restart();
      return 0;
    end
    if (skip_left > 0) begin
      skip_left--;
      return 0;
    end
    if (walk_over) return 0;
    for (int l = 0; l < pbu_pkg::NUM_DIMS; l++)
      if (dim_size(lvl_dim(l)) == 0) return 0;
    vlvl = pbu_pkg::NUM_DIMS - 1;
    for (int l = 0; l < pbu_pkg::NUM_DIMS; l++)
      if (lvl_dim(l) == pbu_pkg::VAR_DIM) vlvl = l;
    vsel = walk_cnt[vlvl] % pbu_pkg::MAX_VARS;
    code = sh_types[3*vsel +: 3];
    case (code)
      pbu_pkg::TYP_I16: size = 2;
      pbu_pkg::TYP_I32, pbu_pkg::TYP_F32: size = 4;
      pbu_pkg::TYP_F64: size = 8;
      default: size = 1;
    endcase
    if (gathered < 8) begin
      gather |= 64'(data) << (8 * gathered);
      gathered++;
    end
    if (gathered < size) return 0;
    raw = '0;
    if (sh_swap) begin
      for (int i = 0; i < size; i++)
        raw |= ((gather >> (8 * i)) & 64'hFF) << (8 * (size - 1 - i));
    end else begin
      raw = (size == 8) ? gather : gather & ((64'd1 << (8 * size)) - 1);
    end
    gather = '0;
    gathered = 0;
    case (code)
      pbu_pkg::TYP_I16: w.value = int_to_double(longint'($signed(raw[15:0])));
      pbu_pkg::TYP_I32: w.value = int_to_double(longint'($signed(raw[31:0])));
      pbu_pkg::TYP_F32: w.value = single_to_double(raw[31:0]);
      pbu_pkg::TYP_F64: w.value = raw;
      default: w.value = int_to_double(longint'($signed(raw[7:0])));
    endcase
    off = '0;
    for (int l = 0; l < pbu_pkg::NUM_DIMS; l++)
      if (lvl_dim(l) < pbu_pkg::NUM_DIMS)
        off += 64'(walk_cnt[l]) * walk_stride[lvl_dim(l)];
    fin = 1'b1;
    for (int l = 0; l < pbu_pkg::NUM_DIMS; l++) begin
      if (walk_cnt[l] + 1 < dim_size(lvl_dim(l))) begin
        walk_cnt[l]++;
        fin = 1'b0;
        break;
      end
      walk_cnt[l] = 0;
    end
    if (fin) walk_over = 1'b1;
    w.written = sh_mask[vsel];
    w.vidx = 3'(vsel);
    w.offset = 60'(off);
    w.last = fin;
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted output word is matched against the oldest
  // pending element, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    elem_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: var %0d off %h val %h",
                                       out_var_index, out_element_offset, out_value_bits);
      end else begin
        e = pending_elems.pop_front();
        if (out_written !== e.written || out_var_index !== e.vidx ||
            out_element_offset !== e.offset || out_value_bits !== e.value ||
            out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp w%0d v%0d off %h val %h last %0d, got w%0d v%0d off %h val %h last %0d",
                     e.written, e.vidx, e.offset, e.value, e.last, out_written,
                     out_var_index, out_element_offset, out_value_bits, out_last);
        end
      end
    end
  end

  // receiver back-pressure in random bursts; no new burst starts once quiet is set
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // the write also updates the shadow registers
  task automatic write_cfg(logic [pbu_pkg::CFG_IDX_W-1:0] idx, logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[pbu_pkg::CFG_W-1:0];
    case (idx)
      pbu_pkg::CFG_DIM_LENGTHS:   sh_lengths = v[59:0];
      pbu_pkg::CFG_DIM_ORDER:     sh_order = v[20:0];
      pbu_pkg::CFG_SWAP_BYTES:    sh_swap = v[0];
      pbu_pkg::CFG_VAR_COUNT:     sh_nvars = v[3:0];
      pbu_pkg::CFG_VAR_TYPES:     sh_types = v[23:0];
      pbu_pkg::CFG_VAR_READ_MASK: sh_mask = v[7:0];
      pbu_pkg::CFG_SKIP_BYTES:    sh_skip = v[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all_cfg(logic [59:0] lens, logic [20:0] ord, logic sw, logic [3:0] nv,
                               logic [23:0] ty, logic [7:0] mk, logic [15:0] sk);
    write_cfg(pbu_pkg::CFG_DIM_LENGTHS, 64'(lens));
    write_cfg(pbu_pkg::CFG_DIM_ORDER, 64'(ord));
    write_cfg(pbu_pkg::CFG_SWAP_BYTES, 64'(sw));
    write_cfg(pbu_pkg::CFG_VAR_COUNT, 64'(nv));
    write_cfg(pbu_pkg::CFG_VAR_TYPES, 64'(ty));
    write_cfg(pbu_pkg::CFG_VAR_READ_MASK, 64'(mk));
    write_cfg(pbu_pkg::CFG_SKIP_BYTES, 64'(sk));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // present one word, wait for the handshake, then predict its outcome
  task automatic send_word(logic mode, logic [7:0] data, logic typed = 0, logic [63:0] tv = 0);
    elem_word_t w;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (unpack_step(mode, data, w)) begin
      if (typed) w.value = tv;
      pending_elems.push_back(w);
    end
  endtask

  // drain: everything back, then cover the pipeline latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Directed walk: lengths all one, five variables, one per type, so the
  // walk is exactly one element per variable and ends on variable 4.
  stim_row_t dir_rows [] = '{
    '{1'b1, 8'h00, 1'b0, 64'h0},
    '{1'b0, 8'h80, 1'b1, 64'hC060_0000_0000_0000},  // int8 -128
    '{1'b0, 8'hFF, 1'b0, 64'h0},
    '{1'b0, 8'h7F, 1'b1, 64'h40DF_FFC0_0000_0000},  // int16 32767
    '{1'b0, 8'h00, 1'b0, 64'h0},
    '{1'b0, 8'h00, 1'b0, 64'h0},
    '{1'b0, 8'h00, 1'b0, 64'h0},
    '{1'b0, 8'h80, 1'b1, 64'hC1E0_0000_0000_0000},  // int32 min
    '{1'b0, 8'h01, 1'b0, 64'h0},
    '{1'b0, 8'h00, 1'b0, 64'h0},
    '{1'b0, 8'h80, 1'b0, 64'h0},
    '{1'b0, 8'h7F, 1'b1, 64'h7FF8_0000_2000_0000},  // signaling NaN made quiet
    '{1'b0, 8'hFF, 1'b0, 64'h0},
    '{1'b0, 8'hFF, 1'b0, 64'h0},
    '{1'b0, 8'hFF, 1'b0, 64'h0},
    '{1'b0, 8'hFF, 1'b0, 64'h0},
    '{1'b0, 8'hFF, 1'b0, 64'h0},
    '{1'b0, 8'hFF, 1'b0, 64'h0},
    '{1'b0, 8'hFF, 1'b0, 64'h0},
    '{1'b0, 8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},  // float64 passed through
    '{1'b0, 8'h55, 1'b0, 64'h0},                    // walk over: ignored
    '{1'b1, 8'h00, 1'b0, 64'h0},
    '{1'b0, 8'h7F, 1'b1, 64'h405F_C000_0000_0000}   // int8 127
  };

  initial begin
    logic [59:0] lens;
    logic [20:0] ord;
    logic [3:0]  nv;
    logic [15:0] sk;
    int unsigned perm [pbu_pkg::NUM_DIMS];
    int unsigned j, t, nitems;

    sh_lengths = '0; sh_order = 21'o6543210; sh_swap = 0; sh_nvars = 1;
    sh_types = '0; sh_mask = 8'hFF; sh_skip = '0;
    walk_restart();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // after reset the lengths are zero, so data words are ignored
    for (int i = 0; i < 3; i++) send_word(1'b0, pick_byte());
    drain();

    write_all_cfg(60'h4010040100401, 21'o6543210, 1'b0, 4'd5, 24'h004688, 8'hFF, 16'd0);
    foreach (dir_rows[i])
      send_word(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].value);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      // small lengths mostly; the occasional zero makes an empty walk
      lens = '0;
      for (int d = 0; d < pbu_pkg::VAR_DIM; d++)
        lens |= 60'($urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 3))
                << (d * pbu_pkg::LEN_BITS);
      for (int i = 0; i < pbu_pkg::NUM_DIMS; i++) perm[i] = i;
      for (int i = pbu_pkg::NUM_DIMS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = perm[i]; perm[i] = perm[j]; perm[j] = t;
      end
      ord = '0;
      for (int i = 0; i < pbu_pkg::NUM_DIMS; i++) ord |= 21'(perm[i]) << (3 * i);
      if ($urandom_range(0, 4) == 0) ord = 21'($urandom_range(0, 21'h1FFFFF));
      nv = $urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      sk = 16'($urandom_range(0, 3));
      case (ph)
        0: lens = M60;               // largest lengths
        1: sk = 16'hFFFF;            // every byte of this phase is header
        2: lens = '0;
        3: ord = 21'h1FFFFF;         // every level unused: one element walk
        4: nv = 4'd15;
        5: ord = 21'o6666666;        // duplicate variable levels
        default: ;
      endcase
      write_all_cfg(lens, ord, 1'($urandom_range(0, 1)), nv,
                    24'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(0, 255)), sk);
      if (ph == 13) quiet = 1'b1;
      send_word(1'b1, 8'($urandom_range(0, 255)));
      nitems = 42;
      for (int i = 0; i < nitems; i++)
        send_word($urandom_range(0, 39) == 0, pick_byte());
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_elems.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
